// ----- hw/rtl/sorted_priority_queue_core_assert.svh -----
// assertion macros for the sorted priority queue core
// expects clk_i and rst_ni in the scope of use
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue cell row.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned PRIO_W = 8;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_FULL  = 2'd1,
    ST_DEQ   = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_e;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] payload;
  } entry_t;

  // operation broadcast to every cell of the row
  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] payload;
  } op_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: keeps its entry, takes the new one, or takes
// a neighbor's entry as the row shifts on insert or removal.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic           clk_i,
  input  spq_pkg::op_t   op_i,
  input  logic           occupied_i,
  input  logic           left_ge_i,
  input  spq_pkg::entry_t left_i,
  input  spq_pkg::entry_t right_i,
  output logic           ge_o,
  output spq_pkg::entry_t ent_o
);
  import spq_pkg::*;

  entry_t ent_q, ent_d;

  // new entry goes behind this one
  assign ge_o = occupied_i && (ent_q.prio >= op_i.prio);

  always_comb begin
    ent_d = ent_q;
    if (op_i.enq && !ge_o) begin
      if (left_ge_i) begin
        ent_d.prio    = op_i.prio;
        ent_d.payload = op_i.payload;
      end else begin
        ent_d = left_i;
      end
    end else if (op_i.deq) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// ----- hw/rtl/sorted_priority_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Max-priority queue of (priority, payload) words; ties leave in arrival order.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result is strobed
// on done_o in the next cycle (busy is high in that cycle), and the following
// word can be taken once busy is low again. A command register feeds the cell
// row: the row of DEPTH cells updates in the busy cycle, each cell keeping,
// replacing or shifting its entry in a single step. Results cannot be stalled;
// the receiver must take each word in the cycle it is strobed. An enqueue into
// a full queue and a dequeue from an empty one return their status with zero
// data.
module sorted_priority_queue_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       kind_i,
  input  logic signed [31:0]         payload_i,
  input  logic [7:0]                 prio_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic signed [31:0]         out_payload_o,
  output logic [7:0]                 out_prio_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic            busy_q;
  logic            enq_q, deq_q;
  logic [PRIO_W-1:0] prio_q;
  logic [DATA_W-1:0] payload_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q;
  status_e         status_q;
  logic [DATA_W-1:0] out_payload_q;
  logic [PRIO_W-1:0] out_prio_q;

  logic            accept;
  logic            full, empty;
  op_t             op;

  entry_t          ent      [DEPTH];
  entry_t          left_ent [DEPTH];
  entry_t          right_ent[DEPTH];
  logic            ge       [DEPTH];
  logic            left_ge  [DEPTH];
  logic            occupied [DEPTH];

  assign accept = start && !busy_q;
  assign full   = (cnt_q == CntW'(DEPTH));
  assign empty  = (cnt_q == '0);

  assign op.enq     = busy_q && enq_q;
  assign op.deq     = busy_q && deq_q;
  assign op.prio    = prio_q;
  assign op.payload = payload_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_row
    assign occupied[i] = (CntW'(i) < cnt_q);
    if (i == 0) begin : g_head
      assign left_ge[i]  = 1'b1;
      assign left_ent[i] = '0;
    end else begin : g_body
      assign left_ge[i]  = ge[i-1];
      assign left_ent[i] = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_ent[i] = '0;
    end else begin : g_inner
      assign right_ent[i] = ent[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .op_i       (op),
      .occupied_i (occupied[i]),
      .left_ge_i  (left_ge[i]),
      .left_i     (left_ent[i]),
      .right_i    (right_ent[i]),
      .ge_o       (ge[i]),
      .ent_o      (ent[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (op.enq) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (op.deq) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      enq_q    <= 1'b0;
      deq_q    <= 1'b0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      status_q <= ST_ENQ;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
        // refused operations leave the row untouched
        enq_q  <= (kind_e'(kind_i) == KIND_ENQ) && !full;
        deq_q  <= (kind_e'(kind_i) == KIND_DEQ) && !empty;
        if (kind_e'(kind_i) == KIND_ENQ) begin
          status_q <= full ? ST_FULL : ST_ENQ;
        end else begin
          status_q <= empty ? ST_EMPTY : ST_DEQ;
        end
      end else begin
        busy_q <= 1'b0;
        enq_q  <= 1'b0;
        deq_q  <= 1'b0;
      end
    end
  end

  // payload side, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prio_q    <= prio_i;
      payload_q <= payload_i;
      if ((kind_e'(kind_i) == KIND_DEQ) && !empty) begin
        out_payload_q <= ent[0].payload;
        out_prio_q    <= ent[0].prio;
      end else begin
        out_payload_q <= '0;
        out_prio_q    <= '0;
      end
    end
  end

  assign busy          = busy_q;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign out_payload_o = out_payload_q;
  assign out_prio_o    = out_prio_q;

`include "sorted_priority_queue_core_assert.svh"

  `SPQ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(DEPTH), "fill count above depth")
  `SPQ_ASSERT_IMP(a_done_busy, done_q, busy_q, "result strobed outside the busy cycle")
  `SPQ_ASSERT_NXT(a_deq_cnt, done_q && (status_q == ST_DEQ), cnt_q == $past(cnt_q) - CntW'(1), "dequeue did not lower the fill count")
  `SPQ_ASSERT_NXT(a_enq_cnt, done_q && (status_q == ST_ENQ), cnt_q == $past(cnt_q) + CntW'(1), "enqueue did not raise the fill count")
  `SPQ_ASSERT_IMP(a_zero_data, done_q && (status_q != ST_DEQ), (out_payload_q == '0) && (out_prio_q == '0), "data not zero on a non-dequeue result")

endmodule
